// ----- design/mqttd_pkg.sv -----
// Shared constants, status codes and result record for the MQTT packet deframer.
package mqttd_pkg;

   localparam int unsigned LEN_DIGITS_DEF  = 4;
   localparam int unsigned DIGIT_W         = 7;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned CNT_W           = 17;
   localparam int unsigned MAXLEN_W        = 16;
   localparam int unsigned STATUS_W        = 3;
   localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

   typedef enum logic [STATUS_W-1:0] {
      ST_RECEIVING = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_BAD_HDR   = 3'd2,
      ST_LEN_ERR   = 3'd3,
      ST_TOO_LONG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [CNT_W-1:0]  byte_index;
      logic              store_byte;
      status_type        status;
      logic [CNT_W-1:0]  packet_len;
   } rsp_type;

endpackage

// ----- design/mqttd_step.sv -----
// Next-state and result logic for one received byte of the deframer.
module mqttd_step #(
   parameter int unsigned LEN_DIGITS = mqttd_pkg::LEN_DIGITS_DEF,
   parameter int unsigned ACC_W      = 7 * LEN_DIGITS,
   parameter int unsigned PH_W       = $clog2(LEN_DIGITS + 2)
) (
   input  logic [mqttd_pkg::BYTE_W-1:0]   in_byte,
   input  logic [mqttd_pkg::MAXLEN_W-1:0] max_payload,
   input  logic [mqttd_pkg::CNT_W-1:0]    byte_count,
   input  logic [PH_W-1:0]                phase,
   input  logic [ACC_W-1:0]               accum,
   output logic [mqttd_pkg::CNT_W-1:0]    byte_count_in,
   output logic [PH_W-1:0]                phase_in,
   output logic [ACC_W-1:0]               accum_in,
   output mqttd_pkg::rsp_type             rsp
);
   import mqttd_pkg::*;

   localparam int unsigned CMP_W = (ACC_W > MAXLEN_W) ? ACC_W : MAXLEN_W;
   localparam logic [PH_W-1:0] PH_DIGITS = PH_W'(LEN_DIGITS);
   localparam logic [PH_W-1:0] PH_BODY   = PH_W'(LEN_DIGITS + 1);

   logic [CNT_W-1:0] cnt_inc;
   logic [ACC_W-1:0] acc_new;
   logic [PH_W-1:0]  phase_inc;

   assign cnt_inc   = byte_count + CNT_W'(1);
   assign phase_inc = phase + PH_W'(1);

   // Digits arrive least significant first into a cleared accumulator: drop each into its slot.
   always_comb begin
      acc_new = accum;
      for (int i = 0; i < LEN_DIGITS; i++) begin
         if (phase == PH_W'(i)) begin
            acc_new[DIGIT_W*i +: DIGIT_W] = in_byte[DIGIT_W-1:0];
         end
      end
   end

   always_comb begin
      byte_count_in  = byte_count;
      phase_in       = phase;
      accum_in       = accum;
      rsp.out_byte   = in_byte;
      rsp.byte_index = byte_count;
      rsp.store_byte = 1'b0;
      rsp.status     = ST_RECEIVING;
      rsp.packet_len = '0;
      if (byte_count == '0) begin
         if (in_byte[3:0] == 4'h0) begin
            rsp.store_byte = 1'b1;
            byte_count_in  = CNT_W'(1);
            phase_in       = '0;
            accum_in       = '0;
         end else begin
            rsp.status    = ST_BAD_HDR;
            byte_count_in = '0;
            phase_in      = '0;
            accum_in      = '0;
         end
      end else if (phase < PH_DIGITS) begin
         rsp.store_byte = 1'b1;
         byte_count_in  = cnt_inc;
         accum_in       = acc_new;
         if (in_byte[BYTE_W-1]) begin
            phase_in = phase_inc;
            if (phase_inc >= PH_DIGITS) begin
               rsp.status    = ST_LEN_ERR;
               byte_count_in = '0;
               phase_in      = '0;
               accum_in      = '0;
            end
         end else begin
            phase_in = PH_BODY;
            if (CMP_W'(acc_new) > CMP_W'(max_payload)) begin
               rsp.status    = ST_TOO_LONG;
               byte_count_in = '0;
               phase_in      = '0;
               accum_in      = '0;
            end else if (acc_new == '0) begin
               rsp.status     = ST_COMPLETE;
               rsp.packet_len = cnt_inc;
               byte_count_in  = '0;
               phase_in       = '0;
               accum_in       = '0;
            end
         end
      end else if (accum != '0) begin
         rsp.store_byte = 1'b1;
         byte_count_in  = cnt_inc;
         accum_in       = accum - ACC_W'(1);
         if (accum == ACC_W'(1)) begin
            rsp.status     = ST_COMPLETE;
            rsp.packet_len = cnt_inc;
            byte_count_in  = '0;
            phase_in       = '0;
            accum_in       = '0;
         end
      end
   end

endmodule

// ----- design/mqtt_packet_deframer.sv -----
// MQTT packet deframer: header check, remaining-length decode and payload count.
// Result: a byte's result is registered and shows in the cycle after the byte is accepted.
// Throughput: one byte per cycle while rsp_ready is high; the result register
//   frees as it is taken: a new byte is accepted in the same cycle the old result leaves.
// Reset (synchronous, active high): framing state idle waiting for a header,
//   no result pending, max_payload back to 1024.
module mqtt_packet_deframer #(
   parameter int unsigned LEN_DIGITS = mqttd_pkg::LEN_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mqttd_pkg::MAXLEN_W-1:0]   csr_max_payload,
   // received byte channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mqttd_pkg::BYTE_W-1:0]     req_in_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mqttd_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic [mqttd_pkg::CNT_W-1:0]      rsp_byte_index,
   output logic                             rsp_store_byte,
   output logic [mqttd_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mqttd_pkg::CNT_W-1:0]      rsp_packet_len
);
   import mqttd_pkg::*;

   // Remaining length holds LEN_DIGITS base-128 digits; phase also counts the body marker.
   localparam int unsigned ACC_W = DIGIT_W * LEN_DIGITS;
   localparam int unsigned PH_W  = $clog2(LEN_DIGITS + 2);
   localparam logic [PH_W-1:0] PH_BODY = PH_W'(LEN_DIGITS + 1);

   logic [MAXLEN_W-1:0] max_payload_ff;
   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic [ACC_W-1:0]    accum_ff, accum_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                req_beat;

   // User must change configuration only while idle (not enforced); each write is taken at once.
   assign csr_ready = 1'b1;

   // Accept a new byte whenever the result register is empty or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_beat  = req_valid && req_ready;

   mqttd_step #(
      .LEN_DIGITS (LEN_DIGITS),
      .ACC_W      (ACC_W),
      .PH_W       (PH_W)
   ) u_step (
      .in_byte       (req_in_byte),
      .max_payload   (max_payload_ff),
      .byte_count    (byte_count_ff),
      .phase         (phase_ff),
      .accum         (accum_ff),
      .byte_count_in (byte_count_in),
      .phase_in      (phase_in),
      .accum_in      (accum_in),
      .rsp           (rsp_in)
   );

   // Framing state and the result register advance together on each input beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
         byte_count_ff  <= '0;
         phase_ff       <= '0;
         accum_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_max_payload;
         end
         if (req_beat) begin
            byte_count_ff <= byte_count_in;
            phase_ff      <= phase_in;
            accum_ff      <= accum_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load on a beat, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_ff.out_byte;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_store_byte = rsp_ff.store_byte;
   assign rsp_status     = rsp_ff.status;
   assign rsp_packet_len = rsp_ff.packet_len;

   // A completed packet ends on the byte just shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_COMPLETE |->
         rsp_ff.packet_len == rsp_ff.byte_index + CNT_W'(1))
      else $error("packet length does not match final byte index");

   // Only a completed packet carries a length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_COMPLETE |-> rsp_ff.packet_len == '0)
      else $error("packet length set without completion");

   // Idle waiting for a header means the length decoder is cleared too.
   assert property (@(posedge clock) disable iff (reset)
      byte_count_ff == '0 |-> phase_ff == '0 && accum_ff == '0)
      else $error("length state left over while idle");

   // A rejected header is never stored and sits at position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_BAD_HDR |->
         !rsp_ff.store_byte && rsp_ff.byte_index == '0)
      else $error("bad header byte marked for storing");

   // An accepted byte always leaves a result behind, and phase stays in range.
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid_ff && phase_ff <= PH_BODY)
      else $error("accepted byte produced no result");

endmodule
